// ----- src/float_scale_to_saturated_int_unit_macros.svh -----
// Assertion macros for the scale-and-convert unit.
// Used by the top level only; no other dependencies.
`ifndef FLOAT_SCALE_TO_SATURATED_INT_UNIT_MACROS_SVH
`define FLOAT_SCALE_TO_SATURATED_INT_UNIT_MACROS_SVH

// Implication checked in the same cycle
`define FSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle
`define FSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fsi_pkg.sv -----
// Shared types, mode codes and range limits for the scale-and-convert unit.
// No dependencies.
package fsi_pkg;

    localparam int MantW = 24;
    localparam int ProdW = 2 * MantW;
    localparam int QW    = 41;

    typedef enum logic [1:0] {
        MODE_I16 = 2'd0,
        MODE_U16 = 2'd1,
        MODE_U8  = 2'd2,
        MODE_I32 = 2'd3
    } t_mode;

    // unpacked single-precision operand, mantissa normalised to bit 23
    typedef struct packed {
        logic              sign;
        logic [MantW-1:0]  mant;
        logic signed [8:0] expo;
        logic              zero;
        logic              inf;
        logic              nan;
    } t_op;

    // per-transaction control carried down the pipe
    typedef struct packed {
        t_mode mode;
        logic  sign;
        logic  kill;    // result zero, not saturated
        logic  nf;      // value not finite
        logic  bigsat;  // clamp to the limit of the sign
    } t_ctl;

    function automatic logic [31:0] hi_lim(input t_mode m);
        logic [31:0] v;
        begin
            case (m)
                MODE_I16: v = 32'd32767;
                MODE_U16: v = 32'd65535;
                MODE_U8:  v = 32'd255;
                MODE_I32: v = 32'h7FFF_FFFF;
                default:  v = 32'd0;
            endcase
            return v;
        end
    endfunction

    // magnitude of the lower limit
    function automatic logic [31:0] lo_mag(input t_mode m);
        logic [31:0] v;
        begin
            case (m)
                MODE_I16: v = 32'd32768;
                MODE_I32: v = 32'h8000_0000;
                default:  v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- src/fsi_unpack.sv -----
// Splits a single-precision word into sign, exponent and normalised mantissa.
// Depends on fsi_pkg.
module fsi_unpack import fsi_pkg::*; (
    input  logic [31:0] i_bits,
    output t_op         o_op
);
    logic [7:0]  expf;
    logic [22:0] frac;
    logic [4:0]  msb;
    logic [4:0]  shamt;

    assign expf = i_bits[30:23];
    assign frac = i_bits[22:0];

    // leading one of a subnormal fraction
    always_comb begin
        msb = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frac[i]) msb = 5'(i);
        end
    end

    assign shamt = 5'd23 - msb;

    always_comb begin
        o_op.sign = i_bits[31];
        o_op.zero = (expf == 8'd0) && (frac == 23'd0);
        o_op.inf  = (expf == 8'hFF) && (frac == 23'd0);
        o_op.nan  = (expf == 8'hFF) && (frac != 23'd0);
        if (expf == 8'd0) begin
            o_op.mant = {1'b0, frac} << shamt;
            o_op.expo = $signed({4'b0, msb}) - 9'sd149;
        end else begin
            o_op.mant = {1'b1, frac};
            o_op.expo = $signed({1'b0, expf}) - 9'sd127;
        end
    end
endmodule

// ----- src/fsi_round.sv -----
// Normalises the 48-bit product and, for the narrow modes, rounds it to
// single precision (nearest even). Depends on fsi_pkg.
module fsi_round import fsi_pkg::*; (
    input  logic [ProdW-1:0]  i_prod,
    input  logic signed [9:0] i_esum,
    input  logic              i_narrow,
    output logic [ProdW-1:0]  o_norm,
    output logic signed [9:0] o_expo
);
    logic [ProdW-1:0]  n;
    logic signed [9:0] e;
    logic              up;
    logic [MantW:0]    rnd;

    // leading one sits at bit 47 or 46
    always_comb begin
        if (i_prod[ProdW-1]) begin
            n = i_prod;
            e = i_esum + 10'sd1;
        end else begin
            n = i_prod << 1;
            e = i_esum;
        end
    end

    assign up  = n[MantW-1] & ((|n[MantW-2:0]) | n[MantW]);
    assign rnd = {1'b0, n[ProdW-1:MantW]} + {{MantW{1'b0}}, up};

    always_comb begin
        if (!i_narrow) begin
            o_norm = n;
            o_expo = e;
        end else if (rnd[MantW]) begin
            o_norm = {1'b1, {(ProdW-1){1'b0}}};
            o_expo = e + 10'sd1;
        end else begin
            o_norm = {rnd[MantW-1:0], {MantW{1'b0}}};
            o_expo = e;
        end
    end
endmodule

// ----- src/fsi_shift.sv -----
// Aligns the normalised product to the binary point: integer part plus the
// half bit. Depends on fsi_pkg.
module fsi_shift import fsi_pkg::*; (
    input  logic [ProdW-1:0]  i_norm,
    input  logic signed [9:0] i_expo,
    output logic [QW-1:0]     o_q
);
    logic [5:0]       sh;
    logic [ProdW:0]   wide;

    // exponents outside -1..39 give zero here
    assign sh   = 6'(10'sd47 - i_expo);
    assign wide = {i_norm, 1'b0} >> sh;

    always_comb begin
        if (i_expo < -10'sd1 || i_expo > 10'sd39) o_q = '0;
        else                                      o_q = wide[QW-1:0];
    end
endmodule

// ----- src/fsi_clamp.sv -----
// Rounds half away from zero and clamps to the range of the mode.
// Depends on fsi_pkg.
module fsi_clamp import fsi_pkg::*; (
    input  logic [QW-1:0] i_q,
    input  t_ctl          i_ctl,
    output logic [31:0]   o_result,
    output logic          o_sat
);
    logic [QW-1:0] mag;
    logic [31:0]   hi;
    logic [31:0]   lom;
    logic [31:0]   lo;

    assign mag = {1'b0, i_q[QW-1:1]} + {{(QW-1){1'b0}}, i_q[0]};
    assign hi  = hi_lim(i_ctl.mode);
    assign lom = lo_mag(i_ctl.mode);
    assign lo  = 32'd0 - lom;

    always_comb begin
        o_result = 32'd0;
        o_sat    = 1'b0;
        if (i_ctl.kill) begin
            o_result = 32'd0;
        end else if (i_ctl.bigsat) begin
            o_sat    = 1'b1;
            o_result = i_ctl.sign ? lo : hi;
        end else if (i_ctl.sign) begin
            if (mag > {9'd0, lom}) begin
                o_sat    = 1'b1;
                o_result = lo;
            end else begin
                o_result = 32'd0 - mag[31:0];
            end
        end else begin
            if (mag > {9'd0, hi}) begin
                o_sat    = 1'b1;
                o_result = hi;
            end else begin
                o_result = mag[31:0];
            end
        end
    end
endmodule

// ----- src/float_scale_to_saturated_int_unit.sv -----
//  channel | valid   | stall   | payload
//  in      | i_valid | o_stall | i_cmd, i_value_bits, i_scale_bits
//  out     | o_valid | i_stall | o_result, o_saturated, o_not_finite
//
// Five register stages: unpack, 24x24 multiply, normalise/round, align,
// round-and-clamp. One transaction per cycle while the output is not stalled;
// the multiplier and the alignment shifter each have a stage of their own.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
// Depends on fsi_pkg and the fsi_* stage modules.
`include "float_scale_to_saturated_int_unit_macros.svh"
module float_scale_to_saturated_int_unit import fsi_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_value_bits,
    input  logic [31:0] i_scale_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result,
    output logic        o_saturated,
    output logic        o_not_finite
);
    logic en;

    t_op  va, vs;
    t_ctl n_ctl1;
    t_ctl n_ctl3;
    logic signed [9:0] n_esum;

    logic                r_v1, r_v2, r_v3, r_v4, r_v5;
    t_ctl                r_ctl1, r_ctl2, r_ctl3, r_ctl4;
    logic [MantW-1:0]    r_ma1, r_mb1;
    logic signed [9:0]   r_esum1, r_esum2, r_e3;
    logic [ProdW-1:0]    r_prod2, r_n3;
    logic [QW-1:0]       r_q4;
    logic [31:0]         r_result5;
    logic                r_sat5, r_nf5;

    logic [ProdW-1:0]    n_norm;
    logic signed [9:0]   n_e;
    logic [QW-1:0]       n_q;
    logic [31:0]         n_result;
    logic                n_sat;
    logic                uns;

    // pipe moves unless a finished result is held
    assign en      = !(r_v5 && i_stall);
    assign o_stall = r_v5 && i_stall;

    // stage 1: classify operands
    fsi_unpack u_unpack_v (.i_bits(i_value_bits), .o_op(va));
    fsi_unpack u_unpack_s (.i_bits(i_scale_bits), .o_op(vs));

    assign uns = (t_mode'(i_cmd) == MODE_U16) || (t_mode'(i_cmd) == MODE_U8);

    always_comb begin
        n_ctl1.mode   = t_mode'(i_cmd);
        n_ctl1.sign   = va.sign ^ vs.sign;
        n_ctl1.nf     = va.inf || va.nan;
        n_ctl1.kill   = va.inf || va.nan || (uns && (va.sign || va.zero)) ||
                        vs.nan || va.zero || vs.zero;
        n_ctl1.bigsat = vs.inf;
        n_esum        = $signed({va.expo[8], va.expo}) + $signed({vs.expo[8], vs.expo});
    end

    // stage 3, 4 and 5 logic
    fsi_round u_round (
        .i_prod(r_prod2), .i_esum(r_esum2), .i_narrow(r_ctl2.mode != MODE_I32),
        .o_norm(n_norm), .o_expo(n_e)
    );
    fsi_shift u_shift (.i_norm(r_n3), .i_expo(r_e3), .o_q(n_q));
    fsi_clamp u_clamp (.i_q(r_q4), .i_ctl(r_ctl4), .o_result(n_result), .o_sat(n_sat));

    // product of 2^40 or more clamps to the limit of its sign
    always_comb begin
        n_ctl3        = r_ctl2;
        n_ctl3.bigsat = r_ctl2.bigsat || (!r_ctl2.kill && (n_e >= 10'sd40));
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl1  <= n_ctl1;
            r_ma1   <= va.mant;
            r_mb1   <= vs.mant;
            r_esum1 <= n_esum;

            r_ctl2  <= r_ctl1;
            r_prod2 <= r_ma1 * r_mb1;
            r_esum2 <= r_esum1;

            r_ctl3  <= n_ctl3;
            r_n3    <= n_norm;
            r_e3    <= n_e;

            r_ctl4 <= r_ctl3;
            r_q4   <= n_q;

            r_result5 <= n_result;
            r_sat5    <= n_sat && !r_ctl4.nf;
            r_nf5     <= r_ctl4.nf;
        end
    end

    assign o_valid      = r_v5;
    assign o_result     = r_result5;
    assign o_saturated  = r_sat5;
    assign o_not_finite = r_nf5;

    `FSI_ASSERT_NOW(a_nf_zero, o_valid && o_not_finite, !o_saturated && (o_result == '0), "nf")
    `FSI_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_result), "held result lost")
    `FSI_ASSERT_NOW(a_stall_src, o_stall, o_valid, "input stalled without a waiting result")

endmodule

// ----- dv/tb_float_scale_to_saturated_int_unit.sv -----
// Testbench for the scale-and-convert unit: drives directed and random
// transactions and checks every result against a bit-level predictor.
// Depends on fsi_pkg and float_scale_to_saturated_int_unit.
`timescale 1ns / 100ps

module tb_float_scale_to_saturated_int_unit import fsi_pkg::*; ();

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_RANDOM    = 1200;
    localparam int  N_QUIET     = 200;
    localparam int  PIPE_DRAIN  = 12;

    // Handy single-precision encodings
    localparam logic [31:0] F_ONE     = 32'h3F80_0000;
    localparam logic [31:0] F_HALF    = 32'h3F00_0000;
    localparam logic [31:0] F_INF     = 32'h7F80_0000;
    localparam logic [31:0] F_NINF    = 32'hFF80_0000;
    localparam logic [31:0] F_NAN     = 32'h7FC0_0000;
    localparam logic [31:0] F_NZERO   = 32'h8000_0000;
    localparam logic [31:0] F_MAXNORM = 32'h7F7F_FFFF;
    localparam logic [31:0] F_MINSUB  = 32'h0000_0001;

    typedef struct {
        logic [31:0] result;
        logic        saturated;
        logic        not_finite;
    } t_conv;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_cmd;
    logic [31:0] i_value_bits;
    logic [31:0] i_scale_bits;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result;
    logic        o_saturated;
    logic        o_not_finite;

    bit quiet;
    int cycles;
    int sink_hold;

    // Scoreboard: predicts each conversion and checks results in order
    class conv_scoreboard;
        t_conv pending_q[$];
        int    n_errors;
        int    n_checked;
        int    n_sat;
        int    n_nf;

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("tb: mismatch %s got %h want %h at cycle %0d", what, got, want, cycles);
            n_errors++;
        endtask

        // Exact product, optional rounding to single precision, then round
        // half away from zero and clamp to the mode's range.
        function void note_input(logic [1:0] cmd, logic [31:0] v, logic [31:0] s);
            t_mode        m;
            longint       lo, hi, r, t;
            logic [127:0] mag, q, rem, halfv;
            logic [23:0]  mv, ms;
            int           ev, es, e, sh, k, d;
            bit           big, neg, narrow, uns;
            t_conv        x;
            m = t_mode'(cmd);
            case (m)
                MODE_I16: begin lo = -32768; hi = 32767; end
                MODE_U16: begin lo = 0; hi = 65535; end
                MODE_U8:  begin lo = 0; hi = 255; end
                default:  begin lo = -64'sd2147483648; hi = 2147483647; end
            endcase
            narrow = (m != MODE_I32);
            uns    = (m == MODE_U16) || (m == MODE_U8);
            ev = v[30:23];
            es = s[30:23];
            mv = (ev == 0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
            ms = (es == 0) ? {1'b0, s[22:0]} : {1'b1, s[22:0]};
            neg = v[31] ^ s[31];
            big = 0;
            mag = '0;
            r = 0;
            x.saturated  = 0;
            x.not_finite = 0;
            if (ev == 255) begin
                x.not_finite = 1;
            end else if (uns && (v[31] || v[30:0] == 0)) begin
                r = 0;
            end else if (es == 255) begin
                // infinite scale: zero when value is zero or scale is NaN, else clamps
                big = (v[30:0] != 0) && (s[22:0] == 0);
            end else begin
                mag = 128'(mv) * 128'(ms);
                e = ((ev == 0) ? -149 : ev - 150) + ((es == 0) ? -149 : es - 150);
                sh = -e;
                if (mag != 0) begin
                    if (e >= 40)
                        big = 1;
                    else if (e >= 0)
                        big = (mag << e) >= (128'd1 << 40);
                    else
                        big = (sh < 120) && ((mag >> sh) >= (128'd1 << 40));
                end
            end
            if (big) begin
                r = neg ? lo : hi;
                x.saturated = 1;
            end else if (mag != 0) begin
                // round to 24 significant bits, nearest even
                if (narrow) begin
                    k = 0;
                    for (int i = 0; i < 48; i++)
                        if (mag[i]) k = i;
                    if (k > 23) begin
                        d = k - 23;
                        q = mag >> d;
                        rem = mag & ((128'd1 << d) - 1);
                        halfv = 128'd1 << (d - 1);
                        if (rem > halfv || (rem == halfv && q[0]))
                            q = q + 1;
                        mag = q << d;
                    end
                end
                if (e >= 0) begin
                    t = longint'(mag << e);
                end else if (sh >= 120) begin
                    t = 0;
                end else begin
                    t = longint'(mag >> sh);
                    if (mag[sh-1]) t++;
                end
                r = neg ? -t : t;
                if (r > hi) begin
                    r = hi;
                    x.saturated = 1;
                end else if (r < lo) begin
                    r = lo;
                    x.saturated = 1;
                end
            end
            x.result = r[31:0];
            pending_q.push_back(x);
        endfunction

        task check_result(logic [31:0] res, logic sat, logic nf);
            t_conv w;
            if (pending_q.size() == 0) begin
                report("unexpected result", res, 32'd0);
                return;
            end
            w = pending_q.pop_front();
            n_checked++;
            if (w.saturated) n_sat++;
            if (w.not_finite) n_nf++;
            if (res !== w.result)    report("result", res, w.result);
            if (sat !== w.saturated) report("saturated", 32'(sat), 32'(w.saturated));
            if (nf !== w.not_finite) report("not_finite", 32'(nf), 32'(w.not_finite));
        endtask
    endclass

    conv_scoreboard sb;

    float_scale_to_saturated_int_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_value_bits (i_value_bits),
        .i_scale_bits (i_scale_bits),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (o_result),
        .o_saturated  (o_saturated),
        .o_not_finite (o_not_finite)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Cycle count and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_result, o_saturated, o_not_finite);
    end

    // Receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 0) begin
            i_stall <= 1'b1;
            sink_hold <= sink_hold - 1;
        end else if ($urandom_range(0, 19) == 0) begin
            i_stall <= 1'b1;
            sink_hold <= $urandom_range(0, 17);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Drive one transaction and wait for it to be taken
    task automatic send_conv(logic [1:0] cmd, logic [31:0] v, logic [31:0] s);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_value_bits <= v;
        i_scale_bits <= s;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(cmd, v, s);
        @(negedge i_clk);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly finite operands whose product lands near the integer ranges
    function automatic logic [31:0] pick_float();
        logic [31:0] f;
        case ($urandom_range(0, 11))
            0, 1: f = $urandom;
            2: begin
                case ($urandom_range(0, 5))
                    0: f = F_INF;
                    1: f = F_NINF;
                    2: f = {1'($urandom_range(0, 1)), 8'hFF, 23'($urandom)};
                    3: f = {1'($urandom_range(0, 1)), 31'd0};
                    4: f = {1'($urandom_range(0, 1)), 8'd0, 23'($urandom)};
                    default: f = {1'($urandom_range(0, 1)), F_MAXNORM[30:0]};
                endcase
            end
            default: f = {1'($urandom_range(0, 1)), 8'($urandom_range(108, 152)),
                          23'($urandom)};
        endcase
        return f;
    endfunction

    // Directed operand pairs, each run in one mode
    logic [31:0] dir_v [0:20] = '{
        F_ONE, F_HALF, 32'h3FC0_0000, 32'hC020_0000, 32'h46FF_FF00, 32'h477F_FF80,
        32'h437F_8000, 32'h4F00_0000, 32'hCF00_0000, F_INF, F_NINF, F_NAN,
        F_NZERO, 32'h0000_0000, F_ONE, 32'h4980_0000, F_MAXNORM, F_MINSUB,
        32'h3EFF_FFFF, 32'hBF00_0000, 32'h3F80_0000
    };
    logic [31:0] dir_s [0:20] = '{
        F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE,
        F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE,
        F_ONE, F_INF, F_NAN, 32'h4980_0000, F_MAXNORM, F_MINSUB,
        32'h3F80_0001, F_ONE, F_NINF
    };

    initial begin
        logic [1:0] cmd;
        bit         ok;
        sb = new();
        quiet = 0;
        cycles = 0;
        sink_hold = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cmd = MODE_I16;
        i_value_bits = '0;
        i_scale_bits = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corner cases; the first four cover all four modes, the rest a random one
        for (int i = 0; i < 21; i++) begin
            cmd = (i < 4) ? 2'(i) : 2'($urandom_range(0, 3));
            send_conv(cmd, dir_v[i], dir_s[i]);
        end
        send_conv(MODE_U8, 32'h437F_8000, F_ONE);
        send_conv(MODE_U16, 32'h3F80_0000, 32'hBF80_0000);
        send_conv(MODE_I32, 32'hCF00_0000, F_ONE);
        send_conv(MODE_U16, 32'h477F_FF80, F_ONE);

        // hold off until the pipe has emptied
        go_idle();
        while (sb.pending_q.size() != 0) @(negedge i_clk);

        // random traffic; the tail runs without any idling
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - N_QUIET) quiet = 1;
            send_conv(2'($urandom_range(0, 3)), pick_float(), pick_float());
        end
        go_idle();

        while (sb.pending_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);

        $display("tb: %0d conversions checked, %0d saturated, %0d non-finite inputs",
                 sb.n_checked, sb.n_sat, sb.n_nf);
        $display("tb: all four modes, specials and random operands with stalls on both sides");
        ok = (sb.n_errors == 0) && (sb.pending_q.size() == 0);
        if (ok) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/fsi_pkg.sv
src/fsi_unpack.sv
src/fsi_round.sv
src/fsi_shift.sv
src/fsi_clamp.sv
src/float_scale_to_saturated_int_unit.sv
dv/tb_float_scale_to_saturated_int_unit.sv
